>>> hdl/assert_macros.svh
// Assertion helpers for the RTL; the top-level file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_SAME(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/mstk_pkg.sv
`default_nettype none
package mstk_pkg;
  localparam int MAX_EDGES  = 256;
  localparam int EIDX_W     = $clog2(MAX_EDGES);
  localparam int ECNT_W     = EIDX_W + 1;
  localparam int VMAX       = 64;
  localparam int VTX_W      = 6;
  localparam int VCNT_W     = 7;
  localparam int COST_W     = 16;
  localparam int TOT_W      = 22;
  localparam int RANK_W     = 3;
  localparam int CHOSEN_W   = 6;
  localparam int EDGE_W     = 2 * VTX_W + COST_W;
  localparam int FENT_W     = RANK_W + VTX_W;
  localparam logic [CHOSEN_W-1:0] CHOSEN_MAX = CHOSEN_W'(63);
  localparam logic [VCNT_W-1:0]   VCNT_RESET = VCNT_W'(64);

  typedef struct packed {
    logic store_edge;
    logic pass_init;
    logic scan_step;
    logic fetch_sel;
    logic take_sel;
    logic walk_step;
    logic root_a;
    logic root_b;
    logic join_link;
    logic join_rank;
    logic emit;
    logic summary;
  } cmd_t;

  typedef struct packed {
    logic pass_done;
    logic scan_end;
    logic is_root;
    logic same_root;
    logic tie;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> hdl/mstk_ctrl.sv
`default_nettype none
module mstk_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         in_final_edge,
  input  wire mstk_pkg::sts_t sts,
  output logic              in_stall,
  output mstk_pkg::cmd_t    cmd
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PASS     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SCAN_END = 4'd3;
  localparam logic [3:0] S_FETCH_RD = 4'd4;
  localparam logic [3:0] S_FETCH    = 4'd5;
  localparam logic [3:0] S_FA_RD    = 4'd6;
  localparam logic [3:0] S_FA_CHK   = 4'd7;
  localparam logic [3:0] S_FB_RD    = 4'd8;
  localparam logic [3:0] S_FB_CHK   = 4'd9;
  localparam logic [3:0] S_JOIN     = 4'd10;
  localparam logic [3:0] S_JOIN2    = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;
  localparam logic [3:0] S_SUMMARY  = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.store_edge = 1'b1;
          if (in_final_edge) state_nxt = S_PASS;
        end
      end
      S_PASS: begin
        if (sts.pass_done) begin
          state_nxt = S_SUMMARY;
        end else begin
          cmd.pass_init = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_end) state_nxt = S_SCAN_END;
        else cmd.scan_step = 1'b1;
      end
      S_SCAN_END: state_nxt = S_FETCH_RD;
      S_FETCH_RD: begin
        cmd.fetch_sel = 1'b1;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        cmd.take_sel = 1'b1;
        state_nxt = S_FA_RD;
      end
      S_FA_RD: state_nxt = S_FA_CHK;
      S_FA_CHK: begin
        if (sts.is_root) cmd.root_a = 1'b1;
        else cmd.walk_step = 1'b1;
        state_nxt = sts.is_root ? S_FB_RD : S_FA_RD;
      end
      S_FB_RD: state_nxt = S_FB_CHK;
      S_FB_CHK: begin
        if (sts.is_root) cmd.root_b = 1'b1;
        else cmd.walk_step = 1'b1;
        state_nxt = sts.is_root ? S_JOIN : S_FB_RD;
      end
      S_JOIN: begin
        if (sts.same_root) begin
          state_nxt = S_PASS;
        end else begin
          cmd.join_link = 1'b1;
          state_nxt = sts.tie ? S_JOIN2 : S_EMIT;
        end
      end
      S_JOIN2: begin
        cmd.join_rank = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          state_nxt = S_PASS;
        end
      end
      S_SUMMARY: begin
        if (sts.out_free) begin
          cmd.summary = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

>>> hdl/mstk_dp.sv
`default_nettype none
module mstk_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mstk_pkg::cmd_t                  cmd,
  output mstk_pkg::sts_t                       sts,
  input  wire logic                            cfg_wr_en,
  input  wire logic [mstk_pkg::VCNT_W-1:0]     cfg_wr_data,
  input  wire logic [mstk_pkg::VTX_W-1:0]      in_edge_from,
  input  wire logic [mstk_pkg::VTX_W-1:0]      in_edge_to,
  input  wire logic signed [mstk_pkg::COST_W-1:0] in_edge_cost,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_is_summary,
  output logic [mstk_pkg::VTX_W-1:0]           out_tree_from,
  output logic [mstk_pkg::VTX_W-1:0]           out_tree_to,
  output logic signed [mstk_pkg::COST_W-1:0]   out_tree_cost,
  output logic signed [mstk_pkg::TOT_W-1:0]    out_running_total,
  output logic [mstk_pkg::CHOSEN_W-1:0]        out_chosen_count,
  output logic                                 out_overflow_flag,
  output logic                                 out_bad_vertex_flag,
  output logic                                 out_last_result
);
  localparam int VW = mstk_pkg::VTX_W;
  localparam int CW = mstk_pkg::COST_W;
  localparam int RW = mstk_pkg::RANK_W;

  logic [mstk_pkg::EDGE_W-1:0] edge_mem [mstk_pkg::MAX_EDGES];
  logic [mstk_pkg::EDGE_W-1:0] edge_q_r;
  logic [mstk_pkg::FENT_W-1:0] fmem [mstk_pkg::VMAX];
  logic [mstk_pkg::FENT_W-1:0] fq_r;
  logic                        fv_r;
  logic [mstk_pkg::VMAX-1:0]   fvalid_r;

  logic [mstk_pkg::VCNT_W-1:0] vcount_r;
  logic [mstk_pkg::ECNT_W-1:0] cnt_r, pass_r, scan_r;
  logic                        ovf_r, bad_r;
  logic [mstk_pkg::EIDX_W-1:0] rd_idx_r, best_idx_r, last_idx_r;
  logic                        rd_vld_r, best_found_r, have_last_r;
  logic signed [CW-1:0]        best_cost_r, last_cost_r;
  logic [VW-1:0]               sel_from_r, sel_to_r, w_r, ra_r, rb_r;
  logic signed [CW-1:0]        sel_cost_r;
  logic [RW-1:0]               rka_r, rkb_r;
  logic signed [mstk_pkg::TOT_W-1:0] total_r;
  logic [mstk_pkg::CHOSEN_W-1:0]     chosen_r;

  logic [mstk_pkg::EIDX_W-1:0] edge_addr;
  logic                        bad_v, full, store_ok;
  logic [VW-1:0]               eq_from, eq_to, parent;
  logic signed [CW-1:0]        eq_cost;
  logic [RW-1:0]               rank;
  logic                        gt_last, lt_best, cand;
  logic                        f_wr;
  logic [VW-1:0]               f_addr;
  logic [mstk_pkg::FENT_W-1:0] f_data;
  logic signed [mstk_pkg::TOT_W-1:0] total_sum;

  assign bad_v    = ({1'b0, in_edge_from} >= vcount_r) || ({1'b0, in_edge_to} >= vcount_r);
  assign full     = (cnt_r == mstk_pkg::ECNT_W'(mstk_pkg::MAX_EDGES));
  assign store_ok = !bad_v && !full;

  assign edge_addr = cmd.fetch_sel ? best_idx_r : scan_r[mstk_pkg::EIDX_W-1:0];
  assign eq_from   = edge_q_r[mstk_pkg::EDGE_W-1 -: VW];
  assign eq_to     = edge_q_r[CW +: VW];
  assign eq_cost   = edge_q_r[CW-1:0];

  // Next key strictly above the last one taken, in (cost, arrival) order.
  assign gt_last = !have_last_r || (eq_cost > last_cost_r) ||
                   ((eq_cost == last_cost_r) && (rd_idx_r > last_idx_r));
  assign lt_best = !best_found_r || (eq_cost < best_cost_r);
  assign cand    = rd_vld_r && gt_last && lt_best;

  assign parent = fv_r ? fq_r[VW-1:0] : w_r;
  assign rank   = fv_r ? fq_r[mstk_pkg::FENT_W-1 -: RW] : '0;

  assign f_wr   = cmd.join_link || cmd.join_rank;
  always_comb begin
    if (cmd.join_rank) begin
      f_addr = ra_r;
      f_data = {rka_r + RW'(1), ra_r};
    end else if (rka_r < rkb_r) begin
      f_addr = ra_r;
      f_data = {rka_r, rb_r};
    end else begin
      f_addr = rb_r;
      f_data = {rkb_r, ra_r};
    end
  end

  assign total_sum = total_r + mstk_pkg::TOT_W'(sel_cost_r);

  assign sts.pass_done = (pass_r == cnt_r) || (chosen_r == mstk_pkg::CHOSEN_MAX);
  assign sts.scan_end  = (scan_r == cnt_r);
  assign sts.is_root   = (parent == w_r);
  assign sts.same_root = (ra_r == rb_r);
  assign sts.tie       = (rka_r == rkb_r);
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.store_edge && store_ok)
      edge_mem[cnt_r[mstk_pkg::EIDX_W-1:0]] <= {in_edge_from, in_edge_to, in_edge_cost};
    edge_q_r <= edge_mem[edge_addr];
  end

  always_ff @(posedge clk) begin
    if (f_wr) fmem[f_addr] <= f_data;
    fq_r <= fmem[w_r];
    fv_r <= fvalid_r[w_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r     <= mstk_pkg::VCNT_RESET;
      cnt_r        <= '0;
      pass_r       <= '0;
      scan_r       <= '0;
      ovf_r        <= 1'b0;
      bad_r        <= 1'b0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      have_last_r  <= 1'b0;
      fvalid_r     <= '0;
      total_r      <= '0;
      chosen_r     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
      if (cmd.store_edge) begin
        if (bad_v) bad_r <= 1'b1;
        else if (full) ovf_r <= 1'b1;
        else cnt_r <= cnt_r + 1'b1;
      end
      rd_vld_r <= cmd.scan_step;
      if (cmd.pass_init) begin
        scan_r       <= '0;
        best_found_r <= 1'b0;
      end
      if (cmd.scan_step) scan_r <= scan_r + 1'b1;
      if (cand) best_found_r <= 1'b1;
      if (cmd.take_sel) begin
        have_last_r <= 1'b1;
        pass_r      <= pass_r + 1'b1;
      end
      if (f_wr) fvalid_r[f_addr] <= 1'b1;
      if (cmd.emit || cmd.summary) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cmd.emit) begin
        total_r   <= total_sum;
        chosen_r  <= chosen_r + 1'b1;
      end
      if (cmd.summary) begin
        cnt_r       <= '0;
        pass_r      <= '0;
        ovf_r       <= 1'b0;
        bad_r       <= 1'b0;
        have_last_r <= 1'b0;
        fvalid_r    <= '0;
        total_r     <= '0;
        chosen_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) rd_idx_r <= scan_r[mstk_pkg::EIDX_W-1:0];
    if (cand) begin
      best_cost_r <= eq_cost;
      best_idx_r  <= rd_idx_r;
    end
    if (cmd.take_sel) begin
      last_cost_r <= best_cost_r;
      last_idx_r  <= best_idx_r;
      sel_from_r  <= eq_from;
      sel_to_r    <= eq_to;
      sel_cost_r  <= eq_cost;
      w_r         <= eq_from;
    end
    if (cmd.walk_step) w_r <= parent;
    if (cmd.root_a) begin
      ra_r  <= w_r;
      rka_r <= rank;
      w_r   <= sel_to_r;
    end
    if (cmd.root_b) begin
      rb_r  <= w_r;
      rkb_r <= rank;
    end
    if (cmd.emit) begin
      out_is_summary      <= 1'b0;
      out_tree_from       <= sel_from_r;
      out_tree_to         <= sel_to_r;
      out_tree_cost       <= sel_cost_r;
      out_running_total   <= total_sum;
      out_chosen_count    <= chosen_r + 1'b1;
      out_overflow_flag   <= 1'b0;
      out_bad_vertex_flag <= 1'b0;
      out_last_result     <= 1'b0;
    end
    if (cmd.summary) begin
      out_is_summary      <= 1'b1;
      out_tree_from       <= '0;
      out_tree_to         <= '0;
      out_tree_cost       <= '0;
      out_running_total   <= total_r;
      out_chosen_count    <= chosen_r;
      out_overflow_flag   <= ovf_r;
      out_bad_vertex_flag <= bad_r;
      out_last_result     <= 1'b1;
    end
  end
endmodule
`default_nettype wire

>>> hdl/minimum_spanning_tree_kruskal_top.sv
// Kruskal minimum spanning tree over up to 256 stored edges and 64 vertices.
// Input channel (in_valid/in_stall): one edge per transaction, taken while
// idle. Edges with a vertex at or above vertex_count, or arriving when 256
// are stored, are dropped and flagged in the summary.
// An edge with in_final_edge set closes the graph and starts the run; in_stall
// is high for the whole run. The run orders edges by a selection scan: each
// chosen position costs one pass over the edge memory, then a walk to the
// root of each endpoint and a union, with a rank update when the ranks tie.
// The single read port of the edge memory sets the pace of the run.
// Result channel (out_valid/out_stall): one transaction per chosen edge with
// the running total, then a summary with last_result set. A stalled result
// holds in the output register and the run waits for it.
// cfg_wr_en/cfg_wr_data write vertex_count (reset 64). Users write it only while idle; the block does not enforce this.
// Synchronous active-low reset empties the edge store, the forest and flags.
`default_nettype none
`include "assert_macros.svh"
module minimum_spanning_tree_kruskal_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mstk_pkg::VCNT_W-1:0]         cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [mstk_pkg::VTX_W-1:0]          in_edge_from,
  input  wire logic [mstk_pkg::VTX_W-1:0]          in_edge_to,
  input  wire logic signed [mstk_pkg::COST_W-1:0]  in_edge_cost,
  input  wire logic                                in_final_edge,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_is_summary,
  output logic [mstk_pkg::VTX_W-1:0]               out_tree_from,
  output logic [mstk_pkg::VTX_W-1:0]               out_tree_to,
  output logic signed [mstk_pkg::COST_W-1:0]       out_tree_cost,
  output logic signed [mstk_pkg::TOT_W-1:0]        out_running_total,
  output logic [mstk_pkg::CHOSEN_W-1:0]            out_chosen_count,
  output logic                                     out_overflow_flag,
  output logic                                     out_bad_vertex_flag,
  output logic                                     out_last_result
);
  mstk_pkg::cmd_t cmd;
  mstk_pkg::sts_t sts;

  mstk_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_final_edge (in_final_edge),
    .sts           (sts),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  mstk_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_edge_from        (in_edge_from),
    .in_edge_to          (in_edge_to),
    .in_edge_cost        (in_edge_cost),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_summary      (out_is_summary),
    .out_tree_from       (out_tree_from),
    .out_tree_to         (out_tree_to),
    .out_tree_cost       (out_tree_cost),
    .out_running_total   (out_running_total),
    .out_chosen_count    (out_chosen_count),
    .out_overflow_flag   (out_overflow_flag),
    .out_bad_vertex_flag (out_bad_vertex_flag),
    .out_last_result     (out_last_result)
  );

  // Edge results never carry the summary flags.
  `CHK_SAME(a_edge_flags, clk, rst_n, out_valid && !out_is_summary, !out_overflow_flag && !out_bad_vertex_flag && !out_last_result)
  // A closing edge starts the run, so input stalls next cycle.
  `CHK_NEXT(a_run_starts, clk, rst_n, in_valid && !in_stall && in_final_edge, in_stall)
  // An edge store and a result load never coincide, nor do the two kinds of result load.
  `CHK_SAME(a_one_load, clk, rst_n, cmd.emit || cmd.summary, !(cmd.emit && cmd.summary) && !cmd.store_edge)
endmodule
`default_nettype wire

>>> tb/tb_minimum_spanning_tree_kruskal_top.sv
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
  logic               summ;
  logic [5:0]         from;
  logic [5:0]         to;
  logic signed [15:0] cost;
  logic signed [21:0] total;
  logic [5:0]         cnt;
  logic               ovf;
  logic               bad;
  logic               last;
} tree_item_t;

class mst_scoreboard;
  logic [6:0]         vcount;
  logic [5:0]         e_from[256];
  logic [5:0]         e_to[256];
  logic signed [15:0] e_cost[256];
  int                 n_stored;
  bit                 ovf_seen;
  bit                 bad_seen;
  int                 parent[64];
  int                 rnk[64];
  int                 ord[256];
  tree_item_t         tree_q[$];
  int                 errors;
  int                 checked;
  int                 graphs;
  int                 edges;

  function new();
    vcount = 7'd64;
    n_stored = 0;
    ovf_seen = 0;
    bad_seen = 0;
    errors = 0;
    checked = 0;
    graphs = 0;
    edges = 0;
  endfunction

  function int root_of(int v);
    int steps;
    steps = 0;
    while (parent[v] != v && steps < 64) begin
      v = parent[v];
      steps++;
    end
    return v;
  endfunction

  function void note_edge(logic [5:0] f, logic [5:0] t, logic signed [15:0] c, logic fin);
    int vc, i, j, cur, a, ra, rb, k;
    logic signed [21:0] total;
    logic [5:0] cnt;
    tree_item_t r;
    edges++;
    vc = (vcount > 64) ? 64 : vcount;
    if (f >= vc || t >= vc) bad_seen = 1;
    else if (n_stored >= 256) ovf_seen = 1;
    else begin
      e_from[n_stored] = f;
      e_to[n_stored] = t;
      e_cost[n_stored] = c;
      n_stored++;
    end
    if (!fin) return;
    graphs++;
    // stable insertion sort on signed cost
    for (i = 0; i < n_stored; i++) begin
      cur = i;
      j = i;
      while (j > 0 && e_cost[ord[j-1]] > e_cost[cur]) begin
        ord[j] = ord[j-1];
        j--;
      end
      ord[j] = cur;
    end
    for (i = 0; i < 64; i++) begin
      parent[i] = i;
      rnk[i] = 0;
    end
    total = '0;
    cnt = '0;
    k = 0;
    for (i = 0; i < n_stored; i++) begin
      a = ord[i];
      ra = root_of(e_from[a]);
      rb = root_of(e_to[a]);
      if (ra != rb) begin
        if (rnk[ra] < rnk[rb]) parent[ra] = rb;
        else if (rnk[rb] < rnk[ra]) parent[rb] = ra;
        else begin
          parent[rb] = ra;
          rnk[ra]++;
        end
        total = total + e_cost[a];
        cnt = cnt + 6'd1;
        r = '{1'b0, e_from[a], e_to[a], e_cost[a], total, cnt, 1'b0, 1'b0, 1'b0};
        tree_q = {tree_q, r};
        k++;
        if (k >= 63) break;
      end
    end
    r = '{1'b1, 6'd0, 6'd0, 16'sd0, total, cnt, ovf_seen, bad_seen, 1'b1};
    tree_q = {tree_q, r};
    n_stored = 0;
    ovf_seen = 0;
    bad_seen = 0;
  endfunction

  function void check_result(tree_item_t got);
    tree_item_t x;
    checked++;
    if (tree_q.size() == 0) begin
      $error("result with nothing expected");
      errors++;
      return;
    end
    x = tree_q.pop_front();
    if (got.summ !== x.summ) begin
      $error("is_summary exp %0d got %0d", x.summ, got.summ); errors++;
    end
    if (got.from !== x.from) begin
      $error("tree_from exp %0d got %0d", x.from, got.from); errors++;
    end
    if (got.to !== x.to) begin
      $error("tree_to exp %0d got %0d", x.to, got.to); errors++;
    end
    if (got.cost !== x.cost) begin
      $error("tree_cost exp %0d got %0d", x.cost, got.cost); errors++;
    end
    if (got.total !== x.total) begin
      $error("running_total exp %0d got %0d", x.total, got.total); errors++;
    end
    if (got.cnt !== x.cnt) begin
      $error("chosen_count exp %0d got %0d", x.cnt, got.cnt); errors++;
    end
    if (got.ovf !== x.ovf) begin
      $error("overflow_flag exp %0d got %0d", x.ovf, got.ovf); errors++;
    end
    if (got.bad !== x.bad) begin
      $error("bad_vertex_flag exp %0d got %0d", x.bad, got.bad); errors++;
    end
    if (got.last !== x.last) begin
      $error("last_result exp %0d got %0d", x.last, got.last); errors++;
    end
  endfunction
endclass

module tb_minimum_spanning_tree_kruskal_top;
  localparam int CYCLE_LIMIT = 1000000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_wr_en = 1'b0;
  logic [mstk_pkg::VCNT_W-1:0]        cfg_wr_data = '0;
  logic                               in_valid = 1'b0;
  wire                                in_stall;
  logic [mstk_pkg::VTX_W-1:0]         in_edge_from = '0;
  logic [mstk_pkg::VTX_W-1:0]         in_edge_to = '0;
  logic signed [mstk_pkg::COST_W-1:0] in_edge_cost = '0;
  logic                               in_final_edge = 1'b0;
  wire                                out_valid;
  logic                               out_stall = 1'b0;
  wire                                out_is_summary;
  wire [mstk_pkg::VTX_W-1:0]          out_tree_from;
  wire [mstk_pkg::VTX_W-1:0]          out_tree_to;
  wire signed [mstk_pkg::COST_W-1:0]  out_tree_cost;
  wire signed [mstk_pkg::TOT_W-1:0]   out_running_total;
  wire [mstk_pkg::CHOSEN_W-1:0]       out_chosen_count;
  wire                                out_overflow_flag;
  wire                                out_bad_vertex_flag;
  wire                                out_last_result;

  mst_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycles = 0;

  minimum_spanning_tree_kruskal_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_edge_from        (in_edge_from),
    .in_edge_to          (in_edge_to),
    .in_edge_cost        (in_edge_cost),
    .in_final_edge       (in_final_edge),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_summary      (out_is_summary),
    .out_tree_from       (out_tree_from),
    .out_tree_to         (out_tree_to),
    .out_tree_cost       (out_tree_cost),
    .out_running_total   (out_running_total),
    .out_chosen_count    (out_chosen_count),
    .out_overflow_flag   (out_overflow_flag),
    .out_bad_vertex_flag (out_bad_vertex_flag),
    .out_last_result     (out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    tree_item_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_is_summary, out_tree_from, out_tree_to, out_tree_cost, out_running_total,
              out_chosen_count, out_overflow_flag, out_bad_vertex_flag, out_last_result};
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_minimum_spanning_tree_kruskal_top: done, errors");
      $finish;
    end
  end

  task automatic send_edge(logic [5:0] f, logic [5:0] t, logic signed [15:0] c, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_edge_from  <= f;
    in_edge_to    <= t;
    in_edge_cost  <= c;
    in_final_edge <= fin;
    // hold until the transaction is taken
    do @(posedge clk); while (in_stall);
    sb.note_edge(f, t, c, fin);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.tree_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_vcount(logic [6:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.vcount = v;
  endtask

  // kinds: 0 well-formed random, 1 spanning chain, 2 noisy, 3 storage overflow
  task automatic send_graph(int kind);
    int vc, m, i;
    logic [5:0] f, t;
    vc = (sb.vcount > 64) ? 64 : sb.vcount;
    case (kind)
      1: m = (vc >= 2) ? vc + 2 : 1;
      3: m = 260;
      default: m = $urandom_range(1, 20);
    endcase
    for (i = 0; i < m; i++) begin
      if (kind == 1 && i < vc - 1) begin
        f = 6'(i);
        t = 6'(i + 1);
      end else if (kind == 2 || vc == 0) begin
        f = 6'($urandom_range(63));
        t = 6'($urandom_range(63));
      end else begin
        f = 6'($urandom_range(vc - 1));
        t = 6'($urandom_range(vc - 1));
      end
      send_edge(f, t, 16'($urandom), i == m - 1);
    end
  endtask

  initial begin
    int regime, n, kind, pick;
    logic [6:0] v;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, self loop and tied weights at the reset vertex count
    send_edge(6'd0, 6'd63, -16'sd32768, 1'b0);
    send_edge(6'd63, 6'd0, 16'sd32767, 1'b0);
    send_edge(6'd5, 6'd5, 16'sd0, 1'b0);
    send_edge(6'd1, 6'd2, -16'sd1, 1'b0);
    send_edge(6'd62, 6'd63, -16'sd32768, 1'b0);
    send_edge(6'd2, 6'd1, -16'sd1, 1'b1);
    // empty graph after a bad vertex
    write_vcount(7'd4);
    send_edge(6'd4, 6'd1, 16'sd5, 1'b1);
    // vertex count changed part way through a graph
    send_edge(6'd0, 6'd3, 16'sd10, 1'b0);
    drain();
    write_vcount(7'd2);
    send_edge(6'd3, 6'd0, 16'sd1, 1'b0);
    send_edge(6'd1, 6'd0, -16'sd3, 1'b1);
    write_vcount(7'd0);
    send_edge(6'd0, 6'd0, 16'sd7, 1'b1);
    write_vcount(7'd127);
    send_edge(6'd63, 6'd62, 16'sd100, 1'b0);
    send_edge(6'd42, 6'd21, 16'sd300, 1'b1);
    write_vcount(7'd1);
    send_edge(6'd0, 6'd0, 16'sd9, 1'b0);
    send_edge(6'd0, 6'd1, 16'sd9, 1'b1);

    for (regime = 0; regime < 3; regime++) begin
      send_idle_pct  = (regime == 0) ? 21 : (regime == 1) ? 81 : 0;
      recv_stall_pct = (regime == 0) ? 81 : (regime == 1) ? 21 : 0;
      n = sb.edges;
      if (regime == 2) begin
        write_vcount(7'd8);
        send_graph(3);
      end
      while (sb.edges - n < 70) begin
        if ($urandom_range(99) < 30) begin
          pick = $urandom_range(5);
          case (pick)
            0: v = 7'd1;
            1: v = 7'd2;
            2: v = 7'd64;
            3: v = 7'd127;
            default: v = 7'($urandom_range(1, 64));
          endcase
          write_vcount(v);
        end
        pick = $urandom_range(99);
        kind = (pick < 70) ? 0 : (pick < 82) ? 1 : 2;
        send_graph(kind);
      end
      // let every result out before moving on
      drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.tree_q.size() != 0) begin
      $error("%0d results never arrived", sb.tree_q.size());
      sb.errors++;
    end
    $display("ran %0d edges over %0d graphs, %0d results checked", sb.edges, sb.graphs,
             sb.checked);
    $display("vertex counts from 0 to 127 with stalls on both channels and a full store");
    if (sb.errors == 0) $display("tb_minimum_spanning_tree_kruskal_top: done, clean");
    else $display("tb_minimum_spanning_tree_kruskal_top: done, errors");
    $finish;
  end
endmodule

`default_nettype wire
